FILE: hdl/hbtt_pkg.sv
// shared types and constants for the hash bucket tombstone table
package hbtt_pkg;

  localparam int CFG_W       = 6;
  localparam int BLOCK_W     = 32;
  localparam int RSLOT_W     = 16;
  localparam int MAX_RESULTS = 32;
  localparam int FCW         = $clog2(MAX_RESULTS + 1);

  localparam logic [CFG_W-1:0] SLOTS_RESET = 6'd32;

  typedef enum logic [1:0] {
    ACT_LOOKUP,
    ACT_INSERT,
    ACT_REMOVE
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

endpackage

FILE: hdl/hash_bucket_tombstone_table.sv
// hash bucket of key and row-id slots with live and used bit maps
//
//  channel   signals                                   transfer when
//  command   start busy action key rid_block rid_slot  start && !busy
//  result    done ok found_block found_slot last       done (one cycle, no stall)
//            is_full is_empty
//  config    cfg_valid cfg_ready cfg_data              cfg_valid && cfg_ready
//
// an item walks n = min(slots_in_use, SLOT_COUNT) slots at most, one slot per
// cycle through the single read port of the slot memory, then closes the
// operation in a finish state; a scan stops early at a never-used slot, an
// insert stops at its target slot or at a live copy of its pair. the final
// result strobes in the cycle after that, while busy is already low. reset clears the bit maps at once, no sweep.
// results cannot be stalled; lookup hits stream out as the scan finds them.
module hash_bucket_tombstone_table
  import hbtt_pkg::*;
#(
  parameter int SLOT_COUNT = 32,
  parameter int KEY_BITS   = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         action,
  input  logic [31:0]        key,
  input  logic [BLOCK_W-1:0] rid_block,
  input  logic [RSLOT_W-1:0] rid_slot,
  output logic               done,
  output logic               ok,
  output logic [BLOCK_W-1:0] found_block,
  output logic [RSLOT_W-1:0] found_slot,
  output logic               last,
  output logic               is_full,
  output logic               is_empty,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CFG_W-1:0]   cfg_data
);

  localparam int IW = $clog2(SLOT_COUNT);
  localparam int CW = $clog2(SLOT_COUNT + 1);
  localparam int KW = (KEY_BITS < 32) ? KEY_BITS : 32;
  localparam int EW = KW + BLOCK_W + RSLOT_W;

  state_t state, state_next;

  logic [CFG_W-1:0]      slots_in_use;
  logic [SLOT_COUNT-1:0] live_map;
  logic [SLOT_COUNT-1:0] used_map;
  logic [CW-1:0]         idx;
  logic [FCW-1:0]        found_cnt;
  logic                  pend_valid;
  logic                  op_ok;

  logic [1:0]            act_r;
  logic [KW-1:0]         key_r;
  logic [BLOCK_W-1:0]    blk_r;
  logic [RSLOT_W-1:0]    slt_r;
  logic [BLOCK_W-1:0]    pend_blk;
  logic [RSLOT_W-1:0]    pend_slt;

  logic [EW-1:0]         mem [SLOT_COUNT];
  logic [EW-1:0]         rdata;
  logic [IW-1:0]         raddr;

  logic [CFG_W:0]        cfg_ext;
  logic [CW-1:0]         n_use;
  logic [CW-1:0]         idx_inc;
  logic [SLOT_COUNT-1:0] umask;
  logic [SLOT_COUNT-1:0] reach;
  logic                  accept;
  logic                  last_slot;
  logic                  slot_live;
  logic                  slot_used;
  logic                  key_hit;
  logic                  pair_hit;
  logic                  scan_stop;
  logic                  hit;
  logic                  kill;
  logic                  mem_we;
  logic [KW-1:0]         rkey;
  logic [BLOCK_W-1:0]    rblk;
  logic [RSLOT_W-1:0]    rslt;

  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  assign cfg_ext = {1'b0, slots_in_use};
  assign n_use   = (cfg_ext > (CFG_W+1)'(SLOT_COUNT)) ? CW'(SLOT_COUNT) : CW'(cfg_ext);
  assign idx_inc = idx + CW'(1);
  assign last_slot = (idx_inc == n_use);

  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      umask[i] = (CW'(i) < n_use);
    end
  end

  // trailing run of used slots, up to the first never-used one
  assign reach    = used_map & ~(used_map + SLOT_COUNT'(1));
  assign is_full  = &(~umask | (used_map & live_map));
  assign is_empty = ~|(live_map & reach & umask);

  assign rkey = rdata[EW-1 -: KW];
  assign rblk = rdata[RSLOT_W +: BLOCK_W];
  assign rslt = rdata[RSLOT_W-1:0];

  assign slot_live = live_map[idx[IW-1:0]];
  assign slot_used = used_map[idx[IW-1:0]];
  assign key_hit   = slot_live && (rkey == key_r);
  assign pair_hit  = key_hit && (rblk == blk_r) && (rslt == slt_r);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (n_use == '0 || action == 2'd3) begin
            state_next = ST_FINISH;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (scan_stop) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // outputs and per-slot decisions
  always_comb begin
    busy      = 1'b1;
    raddr     = idx_inc[IW-1:0];
    scan_stop = 1'b0;
    hit       = 1'b0;
    kill      = 1'b0;
    mem_we    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        busy  = 1'b0;
        raddr = '0;
      end
      ST_SCAN: begin
        unique case (act_r)
          ACT_LOOKUP: begin
            if (!slot_used) begin
              scan_stop = 1'b1;
            end else if (key_hit) begin
              hit = 1'b1;
              if (found_cnt == FCW'(MAX_RESULTS - 1)) begin
                scan_stop = 1'b1;
              end
            end
          end
          ACT_INSERT: begin
            if (slot_live) begin
              if (pair_hit) begin
                scan_stop = 1'b1;
              end
            end else begin
              mem_we    = 1'b1;
              scan_stop = 1'b1;
            end
          end
          ACT_REMOVE: begin
            if (!slot_used) begin
              scan_stop = 1'b1;
            end else if (pair_hit) begin
              kill = 1'b1;
            end
          end
          default: begin
            scan_stop = 1'b1;
          end
        endcase
        if (last_slot) begin
          scan_stop = 1'b1;
        end
      end
      ST_FINISH: begin
      end
      default: begin
      end
    endcase
  end

  // slot memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[idx[IW-1:0]] <= {key_r, blk_r, slt_r};
    end
    rdata <= mem[raddr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      slots_in_use <= SLOTS_RESET;
      live_map     <= '0;
      used_map     <= '0;
      idx          <= '0;
      found_cnt    <= '0;
      pend_valid   <= 1'b0;
      op_ok        <= 1'b0;
      done         <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        slots_in_use <= cfg_data;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            idx        <= '0;
            found_cnt  <= '0;
            pend_valid <= 1'b0;
            op_ok      <= 1'b0;
          end
        end
        ST_SCAN: begin
          idx <= idx_inc;
          if (mem_we) begin
            live_map[idx[IW-1:0]] <= 1'b1;
            used_map[idx[IW-1:0]] <= 1'b1;
            op_ok                 <= 1'b1;
          end
          if (kill) begin
            live_map[idx[IW-1:0]] <= 1'b0;
            op_ok                 <= 1'b1;
          end
          if (hit) begin
            found_cnt  <= found_cnt + FCW'(1);
            pend_valid <= 1'b1;
            if (pend_valid) begin
              done <= 1'b1;
            end
          end
        end
        ST_FINISH: begin
          done <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (accept) begin
      act_r <= action;
      key_r <= key[KW-1:0];
      blk_r <= rid_block;
      slt_r <= rid_slot;
    end
    if (state == ST_SCAN && hit) begin
      pend_blk <= rblk;
      pend_slt <= rslt;
      ok          <= 1'b1;
      found_block <= pend_blk;
      found_slot  <= pend_slt;
      last        <= 1'b0;
    end
    if (state == ST_FINISH) begin
      last <= 1'b1;
      if (act_r == ACT_LOOKUP) begin
        ok          <= pend_valid;
        found_block <= pend_valid ? pend_blk : '0;
        found_slot  <= pend_valid ? pend_slt : '0;
      end else begin
        ok          <= op_ok;
        found_block <= '0;
        found_slot  <= '0;
      end
    end
  end

`ifndef ASSERT_OFF
  a_live_implies_used: assert property (@(posedge clk) disable iff (rst)
    (live_map & ~used_map) == '0)
    else $error("live slot that was never used");

  a_insert_target_dead: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> !slot_live && act_r == ACT_INSERT)
    else $error("insert overwrites a live slot");

  a_finish_gives_last: assert property (@(posedge clk) disable iff (rst)
    state == ST_FINISH |=> done && last && state == ST_IDLE)
    else $error("operation closed without a final result");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> idx < n_use)
    else $error("scan past the usable slots");

  a_partial_only_lookup: assert property (@(posedge clk) disable iff (rst)
    done && !last |-> act_r == ACT_LOOKUP && state != ST_IDLE)
    else $error("non-final result outside a lookup scan");
`endif

endmodule
